### rtl/fppc_pkg.sv
// Shared types and constants for the flash page program chunker.
// No dependencies; every other file imports this package.
package fppc_pkg;

  localparam int unsigned PageBytes  = 256;
  localparam int unsigned ChunkBytes = 32;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned WordW    = 32;
  localparam int unsigned LenOutW  = 6;
  localparam int unsigned LaneW    = 2;
  localparam int unsigned LenW     = $clog2(ChunkBytes + 1);
  localparam int unsigned PageW    = $clog2(PageBytes);

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Result slots of one job, in emission order.
  localparam int unsigned NumSlots    = 7;
  localparam int unsigned SlotPreWord = 0;
  localparam int unsigned SlotPreWren = 1;
  localparam int unsigned SlotPreProg = 2;
  localparam int unsigned SlotReset   = 3;
  localparam int unsigned SlotWord    = 4;
  localparam int unsigned SlotWren    = 5;
  localparam int unsigned SlotProg    = 6;

  typedef enum logic [1:0] {
    ActReset   = 2'd0,
    ActWord    = 2'd1,
    ActWren    = 2'd2,
    ActProgram = 2'd3
  } action_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [AddrW-1:0] start_address;
    logic             first_byte;
    logic             last_byte;
  } byte_t;

  typedef struct packed {
    action_e            action;
    logic [WordW-1:0]   word_value;
    logic [AddrW-1:0]   program_address;
    logic [LenOutW-1:0] program_length;
    logic               final_of_run;
  } result_t;

  // Everything one input byte causes: a slot mask plus the operands.
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [WordW-1:0]    pre_word;
    logic [AddrW-1:0]    pre_addr;
    logic [LenW-1:0]     pre_len;
    logic [WordW-1:0]    word;
    logic [AddrW-1:0]    addr;
    logic [LenW-1:0]     len;
  } job_t;

endpackage

### rtl/fppc_byte_if.sv
// Input channel (one byte item) and result channel of the chunker.
// Depends on fppc_pkg.
interface fppc_byte_if;
  import fppc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [AddrW-1:0] start_address;
  logic             first_byte;
  logic             last_byte;

  modport source (output valid, data_byte, start_address, first_byte, last_byte,
                  input ready);
  modport sink (input valid, data_byte, start_address, first_byte, last_byte,
                output ready);
endinterface

interface fppc_result_if;
  import fppc_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [WordW-1:0]   word_value;
  logic [AddrW-1:0]   program_address;
  logic [LenOutW-1:0] program_length;
  logic               final_of_run;

  modport source (output valid, action, word_value, program_address, program_length,
                  final_of_run, input ready);
  modport sink (input valid, action, word_value, program_address, program_length,
                final_of_run, output ready);
endinterface

### rtl/fppc_front.sv
// Front end: accepts bytes, tracks chunk state, builds one job per byte.
// Depends on fppc_pkg.
module fppc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fppc_pkg::byte_t   in_item_i,
  output logic              push_o,
  input  logic              push_ready_i,
  output fppc_pkg::job_t    job_o
);
  import fppc_pkg::*;

  logic [WordW-1:0] pending_word_q, pending_word_d;
  logic [LaneW-1:0] byte_lane_q, byte_lane_d;
  logic [LenW-1:0]  chunk_len_q, chunk_len_d;
  logic [AddrW-1:0] chunk_addr_q, chunk_addr_d;
  logic             chunk_open_q, chunk_open_d;

  logic             accept;
  logic             pre_close;
  logic             keep_open;
  logic [AddrW-1:0] addr1;
  logic [WordW-1:0] word1, word2;
  logic [LaneW-1:0] lane1;
  logic [LenW-1:0]  len1, len2;
  logic             full_word;
  logic [AddrW-1:0] next_addr;
  logic             close;
  job_t             job;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    pre_close = in_item_i.first_byte && chunk_open_q;
    keep_open = chunk_open_q && !in_item_i.first_byte;
    addr1     = in_item_i.first_byte ? in_item_i.start_address : chunk_addr_q;

    word1 = keep_open ? pending_word_q : '0;
    lane1 = keep_open ? byte_lane_q : '0;
    len1  = keep_open ? chunk_len_q : '0;

    word2     = word1 | (WordW'(in_item_i.data_byte) << {lane1, 3'b000});
    len2      = len1 + LenW'(1);
    full_word = (lane1 == LaneW'(3));
    next_addr = addr1 + AddrW'(len2);
    close     = in_item_i.last_byte || (len2 >= LenW'(ChunkBytes)) ||
                (next_addr[PageW-1:0] == '0);

    job                        = '0;
    job.mask[SlotPreWord]      = pre_close && (byte_lane_q != '0);
    job.mask[SlotPreWren]      = pre_close;
    job.mask[SlotPreProg]      = pre_close;
    job.mask[SlotReset]        = !keep_open;
    // a close after a partial word flushes it; a full word goes out anyway
    job.mask[SlotWord]         = full_word || close;
    job.mask[SlotWren]         = close;
    job.mask[SlotProg]         = close;
    job.pre_word               = pending_word_q;
    job.pre_addr               = chunk_addr_q;
    job.pre_len                = chunk_len_q;
    job.word                   = word2;
    job.addr                   = addr1;
    job.len                    = len2;

    if (close) begin
      pending_word_d = '0;
      byte_lane_d    = '0;
      chunk_len_d    = '0;
      chunk_addr_d   = next_addr;
      chunk_open_d   = 1'b0;
    end else begin
      pending_word_d = full_word ? '0 : word2;
      byte_lane_d    = lane1 + LaneW'(1);
      chunk_len_d    = len2;
      chunk_addr_d   = addr1;
      chunk_open_d   = 1'b1;
    end
  end

  assign push_o = accept && (job.mask != '0);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_word_q <= '0;
      byte_lane_q    <= '0;
      chunk_len_q    <= '0;
      chunk_addr_q   <= '0;
      chunk_open_q   <= 1'b0;
    end else if (accept) begin
      pending_word_q <= pending_word_d;
      byte_lane_q    <= byte_lane_d;
      chunk_len_q    <= chunk_len_d;
      chunk_addr_q   <= chunk_addr_d;
      chunk_open_q   <= chunk_open_d;
    end
  end

endmodule

### rtl/fppc_queue.sv
// Short job queue between front and back end, flop based.
// Depends on fppc_pkg.
module fppc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  fppc_pkg::job_t push_job_i,
  output logic           head_valid_o,
  output fppc_pkg::job_t head_job_o,
  input  logic           pop_i
);
  import fppc_pkg::*;

  job_t                 entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = entries_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

endmodule

### rtl/fppc_back.sv
// Back end: walks the head job's slot mask, one result item per cycle
// while the output is taken, into an output register. Depends on fppc_pkg.
module fppc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  fppc_pkg::job_t    head_job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fppc_pkg::result_t out_item_o
);
  import fppc_pkg::*;

  logic [NumSlots-1:0] sent_q, sent_d;
  logic [NumSlots-1:0] remaining, pick;
  logic                is_last, load;
  logic                out_valid_q, out_valid_d;
  result_t             out_item_q, item_d;

  always_comb begin
    remaining = head_job_i.mask & ~sent_q;
    pick      = remaining & (~remaining + NumSlots'(1));
    is_last   = ((remaining & ~pick) == '0);
    load      = head_valid_i && (!out_valid_q || out_ready_i);

    item_d              = '0;
    item_d.action       = ActReset;
    item_d.final_of_run = is_last;
    if (pick[SlotPreWord]) begin
      item_d.action     = ActWord;
      item_d.word_value = head_job_i.pre_word;
    end
    if (pick[SlotPreWren] || pick[SlotWren]) begin
      item_d.action = ActWren;
    end
    if (pick[SlotPreProg]) begin
      item_d.action          = ActProgram;
      item_d.program_address = head_job_i.pre_addr;
      item_d.program_length  = LenOutW'(head_job_i.pre_len);
    end
    if (pick[SlotWord]) begin
      item_d.action     = ActWord;
      item_d.word_value = head_job_i.word;
    end
    if (pick[SlotProg]) begin
      item_d.action          = ActProgram;
      item_d.program_address = head_job_i.addr;
      item_d.program_length  = LenOutW'(head_job_i.len);
    end

    sent_d = sent_q;
    if (load) begin
      sent_d = is_last ? '0 : (sent_q | pick);
    end

    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  assign pop_o       = load && is_last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/flash_page_program_chunker_core.sv
// Flash page program chunker: front end -> 4-entry job queue -> back end.
// A byte's job is registered in the queue, and its results in the output register.
// Throughput: one byte per cycle while bytes cause at most one result each and the
// output is ready; the back end sends a result per cycle, popping a job with its last.
// Reset (rst_ni, async, active low) clears chunk state, queue and output valid.
module flash_page_program_chunker_core (
  input logic           clk_i,
  input logic           rst_ni,
  fppc_byte_if.sink     byte_i,
  fppc_result_if.source result_o
);
  import fppc_pkg::*;

  byte_t   in_item;
  job_t    push_job, head_job;
  logic    push, push_ready, head_valid, pop;
  result_t out_item;

  assign in_item.data_byte     = byte_i.data_byte;
  assign in_item.start_address = byte_i.start_address;
  assign in_item.first_byte    = byte_i.first_byte;
  assign in_item.last_byte     = byte_i.last_byte;

  fppc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .in_ready_o  (byte_i.ready),
    .in_item_i   (in_item),
    .push_o      (push),
    .push_ready_i(push_ready),
    .job_o       (push_job)
  );

  fppc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .head_valid_o(head_valid),
    .head_job_o  (head_job),
    .pop_i       (pop)
  );

  fppc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_job_i  (head_job),
    .pop_o       (pop),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_item_o  (out_item)
  );

  assign result_o.action          = out_item.action;
  assign result_o.word_value      = out_item.word_value;
  assign result_o.program_address = out_item.program_address;
  assign result_o.program_length  = out_item.program_length;
  assign result_o.final_of_run    = out_item.final_of_run;

  // Write enable and its page program come from the same job, back to back.
  a_wren_then_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.ready && result_o.action == ActWren |=>
      result_o.valid && result_o.action == ActProgram)
    else $error("write enable not followed by page program");

  // A non-final result means the rest of its job still sits in the queue.
  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.final_of_run |-> head_valid)
    else $error("job left the queue before its last result");

  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.action != ActWord |-> result_o.word_value == '0)
    else $error("word value set on a non-data result");

  a_program_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.action != ActProgram |->
      result_o.program_address == '0 && result_o.program_length == '0)
    else $error("program fields set on a non-program result");

endmodule
